### rtl/core/i2cee_pkg.sv
// Package for the I2C EEPROM byte access master.
// Holds the sequencer phase type, command and register codes, bus timing
// and reset constants. No dependencies.
`default_nettype none

package i2cee_pkg;

   // Sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START   = 4'd1,
      PH_SEND    = 4'd2,
      PH_ACKPREP = 4'd3,
      PH_ACKPOLL = 4'd4,
      PH_READ    = 4'd5,
      PH_NACK    = 4'd6,
      PH_STOP    = 4'd7,
      PH_WAIT    = 4'd8
   } phase_type;

   // Command codes on the func field.
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_DEVICE_ADDRESS   = 2'd0,
      REG_ACK_TIMEOUT      = 2'd1,
      REG_WRITE_CYCLE_WAIT = 2'd2,
      REG_UNUSED           = 2'd3
   } reg_index_type;

   // Register widths and reset values.
   localparam int unsigned DEV_ADDR_W   = 7;
   localparam int unsigned TIMEOUT_W    = 8;
   localparam int unsigned WAIT_W       = 16;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd80;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 8'd250;
   localparam logic [WAIT_W-1:0]     WAIT_RESET     = 16'd10000;

   // Bus timing in ticks.
   localparam logic [WAIT_W-1:0] START_HALF = 16'd4;
   localparam logic [WAIT_W-1:0] START_LEN  = 16'd8;
   localparam logic [WAIT_W-1:0] BIT_LEN    = 16'd6;
   localparam logic [WAIT_W-1:0] ACKPREP_LEN = 16'd2;
   localparam logic [WAIT_W-1:0] READ_LEN   = 16'd3;
   localparam logic [WAIT_W-1:0] NACK_LEN   = 16'd4;
   localparam logic [WAIT_W-1:0] STOP_HALF  = 16'd4;
   localparam logic [WAIT_W-1:0] STOP_LEN   = 16'd8;
   localparam logic [3:0]        BYTE_BITS  = 4'd8;

   // Byte sequence positions.
   localparam logic [2:0] IDX_ADDR_HI  = 3'd1;
   localparam logic [2:0] IDX_ADDR_LO  = 3'd2;
   localparam logic [2:0] IDX_DATA     = 3'd3;
   localparam logic [2:0] IDX_READ_DEV = 3'd4;
   localparam logic [2:0] IDX_READ_BIT = 3'd5;

endpackage

`default_nettype wire

### rtl/core/i2c_eeprom_byte_access_master.sv
// Top level of the I2C EEPROM byte access master: configuration registers,
// bus sequencer and the result word register. Depends on i2cee_pkg.
//
// Each request word is one bus tick; its result word appears in the cycle after
// acceptance. One word is accepted every cycle while the result side takes
// words; the single result register sets that rate.
// Reset (synchronous, active high) returns the sequencer to idle and loads
// the register defaults: device address 80, ack timeout 250, write wait 10000.
`default_nettype none

module i2c_eeprom_byte_access_master
   import i2cee_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_mem_addr,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_sda_in,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_sda_drive,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_ack_error,
   output logic [7:0]       rsp_read_data,
   // Configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [DEV_ADDR_W-1:0] dev_addr_ff;
   logic [TIMEOUT_W-1:0]  ack_timeout_ff;
   logic [WAIT_W-1:0]     wait_len_ff;

   // Sequencer state.
   phase_type       phase_ff, phase_in;
   logic [3:0]      bit_cnt_ff, bit_cnt_in;
   logic [2:0]      byte_idx_ff, byte_idx_in;
   logic [7:0]      shift_ff, shift_in;
   logic [WAIT_W-1:0] tick_ff, tick_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [15:0]     addr_ff, addr_in;
   logic [7:0]      data_ff, data_in;
   logic            is_read_ff, is_read_in;
   logic [7:0]      rx_byte_ff, rx_byte_in;
   logic            error_ff, error_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic            scl_ff, sda_ff, drv_ff, busy_ff, done_ff, err_ff;
   logic [7:0]      rdata_ff;

   logic            accept;
   logic            finish;
   logic [WAIT_W-1:0] tick_inc;
   logic [3:0]      bit_inc;
   logic [2:0]      next_idx;
   logic [7:0]      shift_rx;
   logic            scl_out, sda_out, drv_out;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign tick_inc  = tick_ff + 16'd1;
   assign bit_inc   = bit_cnt_ff + 4'd1;
   assign next_idx  = byte_idx_ff + 3'd1;
   assign shift_rx  = {shift_ff[6:0], req_sda_in};

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEV_ADDR_RESET;
         ack_timeout_ff <= TIMEOUT_RESET;
         wait_len_ff    <= WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_DEVICE_ADDRESS:   dev_addr_ff    <= csr_wdata[DEV_ADDR_W-1:0];
            REG_ACK_TIMEOUT:      ack_timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            REG_WRITE_CYCLE_WAIT: wait_len_ff    <= csr_wdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state of the sequencer for one tick.
   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_idx_in = byte_idx_ff;
      shift_in    = shift_ff;
      tick_in     = tick_ff;
      timeout_in  = timeout_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      is_read_in  = is_read_ff;
      rx_byte_in  = rx_byte_ff;
      error_in    = error_ff;
      finish      = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_func == FUNC_WRITE || req_func == FUNC_READ) begin
               addr_in     = req_mem_addr;
               data_in     = req_write_data;
               is_read_in  = (req_func == FUNC_READ);
               error_in    = 1'b0;
               byte_idx_in = 3'd0;
               phase_in    = PH_START;
               tick_in     = '0;
               bit_cnt_in  = '0;
            end
         end
         PH_START: begin
            tick_in = tick_inc;
            if (tick_inc >= START_LEN) begin
               phase_in   = PH_SEND;
               tick_in    = '0;
               bit_cnt_in = '0;
               shift_in   = {dev_addr_ff, byte_idx_ff == IDX_READ_DEV};
            end
         end
         PH_SEND: begin
            tick_in = tick_inc;
            if (tick_inc >= BIT_LEN) begin
               tick_in    = '0;
               shift_in   = {shift_ff[6:0], 1'b0};
               bit_cnt_in = bit_inc;
               if (bit_inc >= BYTE_BITS) begin
                  phase_in   = PH_ACKPREP;
                  bit_cnt_in = '0;
               end
            end
         end
         PH_ACKPREP: begin
            tick_in = tick_inc;
            if (tick_inc >= ACKPREP_LEN) begin
               phase_in   = PH_ACKPOLL;
               tick_in    = '0;
               bit_cnt_in = '0;
               timeout_in = '0;
            end
         end
         PH_ACKPOLL: begin
            if (!req_sda_in) begin
               // Acknowledge seen: pick the next byte or phase.
               byte_idx_in = next_idx;
               tick_in     = '0;
               bit_cnt_in  = '0;
               priority if (next_idx == IDX_ADDR_HI) begin
                  phase_in = PH_SEND;
                  shift_in = addr_ff[15:8];
               end else if (next_idx == IDX_ADDR_LO) begin
                  phase_in = PH_SEND;
                  shift_in = addr_ff[7:0];
               end else if (next_idx == IDX_DATA && !is_read_ff) begin
                  phase_in = PH_SEND;
                  shift_in = data_ff;
               end else if (next_idx == IDX_DATA && is_read_ff) begin
                  byte_idx_in = IDX_READ_DEV;
                  phase_in    = PH_START;
               end else if (next_idx == IDX_READ_BIT && is_read_ff) begin
                  phase_in = PH_READ;
                  shift_in = '0;
               end else begin
                  phase_in = PH_STOP;
               end
            end else if (timeout_ff >= ack_timeout_ff) begin
               error_in   = 1'b1;
               phase_in   = PH_STOP;
               tick_in    = '0;
               bit_cnt_in = '0;
            end else begin
               timeout_in = timeout_ff + 8'd1;
            end
         end
         PH_READ: begin
            if (tick_ff == 16'd2) begin
               shift_in = shift_rx;
            end
            tick_in = tick_inc;
            if (tick_inc >= READ_LEN) begin
               tick_in    = '0;
               bit_cnt_in = bit_inc;
               if (bit_inc >= BYTE_BITS) begin
                  rx_byte_in = shift_in;
                  phase_in   = PH_NACK;
                  bit_cnt_in = '0;
               end
            end
         end
         PH_NACK: begin
            tick_in = tick_inc;
            if (tick_inc >= NACK_LEN) begin
               phase_in   = PH_STOP;
               tick_in    = '0;
               bit_cnt_in = '0;
            end
         end
         PH_STOP: begin
            tick_in = tick_inc;
            if (tick_inc >= STOP_LEN) begin
               if (!is_read_ff && !error_ff && wait_len_ff != '0) begin
                  phase_in   = PH_WAIT;
                  tick_in    = '0;
                  bit_cnt_in = '0;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         PH_WAIT: begin
            tick_in = tick_inc;
            if (tick_inc >= wait_len_ff) begin
               finish = 1'b1;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            tick_in    = '0;
            bit_cnt_in = '0;
         end
      endcase

      if (finish) begin
         phase_in   = PH_IDLE;
         tick_in    = '0;
         bit_cnt_in = '0;
      end
   end

   // Bus line levels for the current tick.
   always_comb begin
      scl_out = 1'b1;
      sda_out = 1'b1;
      drv_out = 1'b1;
      unique case (phase_ff)
         PH_START: sda_out = (tick_ff < START_HALF);
         PH_SEND: begin
            scl_out = (tick_ff == 16'd2) || (tick_ff == 16'd3);
            sda_out = shift_ff[7];
         end
         PH_ACKPREP: begin
            drv_out = 1'b0;
            scl_out = (tick_ff == 16'd1);
         end
         PH_ACKPOLL: drv_out = 1'b0;
         PH_READ: begin
            drv_out = 1'b0;
            scl_out = (tick_ff == 16'd2);
         end
         PH_NACK: scl_out = (tick_ff >= 16'd2);
         PH_STOP: begin
            if (tick_ff < STOP_HALF) begin
               scl_out = 1'b0;
               sda_out = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Sequencer state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_cnt_ff  <= '0;
         byte_idx_ff <= '0;
         shift_ff    <= '0;
         tick_ff     <= '0;
         timeout_ff  <= '0;
         addr_ff     <= '0;
         data_ff     <= '0;
         is_read_ff  <= 1'b0;
         rx_byte_ff  <= '0;
         error_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_idx_ff <= byte_idx_in;
         shift_ff    <= shift_in;
         tick_ff     <= tick_in;
         timeout_ff  <= timeout_in;
         addr_ff     <= addr_in;
         data_ff     <= data_in;
         is_read_ff  <= is_read_in;
         rx_byte_ff  <= rx_byte_in;
         error_ff    <= error_in;
      end
   end

   // Result word register.
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff   <= scl_out;
         sda_ff   <= sda_out;
         drv_ff   <= drv_out;
         busy_ff  <= (phase_in != PH_IDLE);
         done_ff  <= finish;
         err_ff   <= finish & error_in;
         rdata_ff <= rx_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = drv_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_ack_error = err_ff;
   assign rsp_read_data = rdata_ff;

   // An accepted word always produces a result word in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // A finished command reports not busy in the same word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("done reported while still busy");

   // An acknowledge error is only reported together with done.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_ff) |-> done_ff)
      else $error("ack error without done");

   // The acknowledge wait never runs past the timeout.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ACKPOLL) |-> (timeout_ff <= ack_timeout_ff))
      else $error("ack timeout counter overran");

   // The master never drives SDA while polling for an acknowledge.
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_ACKPOLL) |=> !drv_ff)
      else $error("SDA driven during acknowledge");

endmodule

`default_nettype wire

### sim/tb_i2c_eeprom_byte_access_master.sv
// Self-checking testbench for the I2C EEPROM byte access master.
// A class predicts the bus levels and flags of every tick word and checks each
// result word against them. Depends on i2cee_pkg and the block's top level.
`default_nettype none

module tb_i2c_eeprom_byte_access_master
   import i2cee_pkg::*;
;

   // One result word: line levels, status flags and the last read byte.
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       drive;
      logic       busy;
      logic       done;
      logic       err;
      logic [7:0] rdata;
   } bus_levels_type;

   // Tracks the sequencer of the block and holds the words still due.
   class bus_level_board_type;
      logic [6:0]  dev_addr;
      logic [7:0]  ack_limit;
      logic [15:0] wait_len;
      phase_type   phase;
      logic [3:0]  bit_cnt;
      logic [2:0]  byte_idx;
      logic [7:0]  shifter;
      logic [15:0] tick_cnt;
      logic [7:0]  poll_cnt;
      logic [15:0] addr_hold;
      logic [7:0]  data_hold;
      logic        reading;
      logic [7:0]  rx_byte;
      logic        err_flag;
      bus_levels_type levels_due[$];
      int unsigned fails;

      function new();
         dev_addr  = DEV_ADDR_RESET;
         ack_limit = TIMEOUT_RESET;
         wait_len  = WAIT_RESET;
         phase     = PH_IDLE;
         bit_cnt   = '0;
         byte_idx  = '0;
         shifter   = '0;
         tick_cnt  = '0;
         poll_cnt  = '0;
         addr_hold = '0;
         data_hold = '0;
         reading   = 1'b0;
         rx_byte   = '0;
         err_flag  = 1'b0;
         fails     = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] val);
         case (idx)
            REG_DEVICE_ADDRESS:   dev_addr = val[6:0];
            REG_ACK_TIMEOUT:      ack_limit = val[7:0];
            REG_WRITE_CYCLE_WAIT: wait_len = val;
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return levels_due.size();
      endfunction

      function void go_to(phase_type p);
         phase    = p;
         tick_cnt = '0;
         bit_cnt  = '0;
      endfunction

      function void load_byte(logic [7:0] b);
         go_to(PH_SEND);
         shifter = b;
      endfunction

      // Picks the next step of the byte sequence once a byte is acknowledged.
      function void ack_seen();
         byte_idx = byte_idx + 3'd1;
         if (byte_idx == IDX_ADDR_HI) begin
            load_byte(addr_hold[15:8]);
         end else if (byte_idx == IDX_ADDR_LO) begin
            load_byte(addr_hold[7:0]);
         end else if (byte_idx == IDX_DATA && !reading) begin
            load_byte(data_hold);
         end else if (byte_idx == IDX_DATA && reading) begin
            byte_idx = IDX_READ_DEV;
            go_to(PH_START);
         end else if (byte_idx == IDX_READ_BIT && reading) begin
            go_to(PH_READ);
            shifter = '0;
         end else begin
            go_to(PH_STOP);
         end
      endfunction

      // Advances the sequencer by one accepted tick and queues its word.
      function void note_tick(func_type f, logic [15:0] a, logic [7:0] d, logic s);
         bus_levels_type w;
         bit wrap_up;
         w = '0;
         w.scl = 1'b1;
         w.sda = 1'b1;
         w.drive = 1'b1;
         wrap_up = 1'b0;
         case (phase)
            PH_IDLE: begin
               if (f == FUNC_WRITE || f == FUNC_READ) begin
                  addr_hold = a;
                  data_hold = d;
                  reading = (f == FUNC_READ);
                  err_flag = 1'b0;
                  byte_idx = '0;
                  go_to(PH_START);
               end
            end
            PH_START: begin
               w.sda = (tick_cnt < START_HALF);
               tick_cnt++;
               if (tick_cnt >= START_LEN)
                  load_byte({dev_addr, byte_idx == IDX_READ_DEV});
            end
            PH_SEND: begin
               // SCL is high in the middle two ticks of each bit.
               w.scl = (tick_cnt == 16'd2 || tick_cnt == 16'd3);
               w.sda = shifter[7];
               tick_cnt++;
               if (tick_cnt >= BIT_LEN) begin
                  tick_cnt = '0;
                  shifter = shifter << 1;
                  bit_cnt++;
                  if (bit_cnt >= BYTE_BITS)
                     go_to(PH_ACKPREP);
               end
            end
            PH_ACKPREP: begin
               w.drive = 1'b0;
               w.scl = (tick_cnt == 16'd1);
               tick_cnt++;
               if (tick_cnt >= ACKPREP_LEN) begin
                  go_to(PH_ACKPOLL);
                  poll_cnt = '0;
               end
            end
            PH_ACKPOLL: begin
               w.drive = 1'b0;
               if (!s) begin
                  ack_seen();
               end else if (poll_cnt >= ack_limit) begin
                  err_flag = 1'b1;
                  go_to(PH_STOP);
               end else begin
                  poll_cnt++;
               end
            end
            PH_READ: begin
               // The data bit is sampled on the single SCL high tick.
               w.drive = 1'b0;
               w.scl = (tick_cnt == 16'd2);
               if (tick_cnt == 16'd2)
                  shifter = {shifter[6:0], s};
               tick_cnt++;
               if (tick_cnt >= READ_LEN) begin
                  tick_cnt = '0;
                  bit_cnt++;
                  if (bit_cnt >= BYTE_BITS) begin
                     rx_byte = shifter;
                     go_to(PH_NACK);
                  end
               end
            end
            PH_NACK: begin
               w.scl = (tick_cnt >= 16'd2);
               tick_cnt++;
               if (tick_cnt >= NACK_LEN)
                  go_to(PH_STOP);
            end
            PH_STOP: begin
               if (tick_cnt < STOP_HALF) begin
                  w.scl = 1'b0;
                  w.sda = 1'b0;
               end
               tick_cnt++;
               if (tick_cnt >= STOP_LEN) begin
                  if (!reading && !err_flag && wait_len != 16'd0)
                     go_to(PH_WAIT);
                  else
                     wrap_up = 1'b1;
               end
            end
            PH_WAIT: begin
               tick_cnt++;
               if (tick_cnt >= wait_len)
                  wrap_up = 1'b1;
            end
            default: go_to(PH_IDLE);
         endcase
         if (wrap_up) begin
            go_to(PH_IDLE);
            w.done = 1'b1;
            w.err = err_flag;
         end
         w.busy = (phase != PH_IDLE);
         w.rdata = rx_byte;
         levels_due.push_back(w);
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
         end
      endfunction

      // Checks one result word against the oldest word due.
      function void check_levels(bus_levels_type got);
         bus_levels_type want;
         if (levels_due.size() == 0) begin
            $error("result word arrived with no tick outstanding");
            fails++;
            return;
         end
         want = levels_due.pop_front();
         compare("scl_level", want.scl, got.scl);
         compare("sda_level", want.sda, got.sda);
         compare("sda_drive", want.drive, got.drive);
         compare("busy_res", want.busy, got.busy);
         compare("done_res", want.done, got.done);
         compare("ack_error", want.err, got.err);
         compare("read_data", want.rdata, got.rdata);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = 2'd0;
   logic [15:0] req_mem_addr = 16'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ack_error;
   logic [7:0]  rsp_read_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bus_level_board_type board;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned sent_items = 0;

   i2c_eeprom_byte_access_master uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_mem_addr   (req_mem_addr),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_ack_error  (rsp_ack_error),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side: check every accepted word, then pick the next stall level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_levels({rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_busy_res,
                             rsp_done_res, rsp_ack_error, rsp_read_data});
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Offers one tick word, with random gaps ahead of it, and waits for acceptance.
   task automatic send_tick(input func_type f, input logic [15:0] a, input logic [7:0] d,
                            input logic s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_mem_addr   <= a;
      req_write_data <= d;
      req_sda_in     <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_tick(f, a, d, s);
      sent_items++;
   endtask

   // Issues one command and plays the slave until the master is idle again.
   // Each acknowledge poll is answered low with the given percent chance.
   task automatic run_command(input func_type f, input logic [15:0] a, input logic [7:0] d,
                              input int unsigned ack_pct, input logic [7:0] rd_byte);
      logic s;
      send_tick(f, a, d, 1'($urandom));
      while (board.phase != PH_IDLE) begin
         s = 1'($urandom);
         if (board.phase == PH_ACKPOLL) begin
            s = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
         end else if (board.phase == PH_READ) begin
            if (board.tick_cnt == 16'd2)
               s = rd_byte[3'd7 - board.bit_cnt[2:0]];
         end
         // Commands offered while busy must be ignored.
         send_tick(func_type'(2'($urandom)), 16'($urandom), 8'($urandom), s);
      end
   endtask

   // Stops offering words until every predicted word has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.set_reg(idx, val);
   endtask

   // Writes all registers; the unused bits carry random junk that must be dropped.
   task automatic configure(input logic [6:0] dev, input logic [7:0] tmo,
                            input logic [15:0] wlen);
      logic [8:0] dev_junk;
      logic [7:0] tmo_junk;
      dev_junk = 9'($urandom);
      tmo_junk = 8'($urandom);
      write_reg(REG_DEVICE_ADDRESS, {dev_junk, dev});
      write_reg(REG_UNUSED, 16'($urandom));
      write_reg(REG_ACK_TIMEOUT, {tmo_junk, tmo});
      write_reg(REG_WRITE_CYCLE_WAIT, wlen);
      csr_valid <= 1'b0;
   endtask

   // Random commands and idle noise until the tick budget is used up.
   task automatic run_random(input int unsigned budget);
      int unsigned stop_at;
      stop_at = sent_items + budget;
      while (sent_items < stop_at) begin
         case ($urandom_range(0, 9))
            0: send_tick(FUNC_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
            1: send_tick(FUNC_SPARE, 16'($urandom), 8'($urandom), 1'($urandom));
            default: run_command($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                                 16'($urandom), 8'($urandom),
                                 ($urandom_range(0, 4) == 0) ? 0 : 50, 8'($urandom));
         endcase
      end
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset defaults: idle codes, extremes and a full read.
      run_command(FUNC_TICK, 16'h0000, 8'h00, 100, 8'h00);
      run_command(FUNC_SPARE, 16'hFFFF, 8'hFF, 100, 8'h00);
      run_command(FUNC_READ, 16'hFFFF, 8'hFF, 100, 8'hFF);
      settle();

      // Zero ack timeout fails on the first high sample; a failed read keeps
      // the old byte.
      configure(7'h7F, 8'd0, 16'd0);
      run_command(FUNC_WRITE, 16'h8001, 8'h5A, 0, 8'h00);
      run_command(FUNC_READ, 16'h1234, 8'h00, 0, 8'hA5);
      settle();

      // Random part: one register setting under each idling pattern.
      for (int seg = 0; seg < 4; seg++) begin
         case (seg)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               configure(7'h00, 8'd1, 16'd0);
            end
            1: begin
               send_idle_pct = 51; recv_stall_pct = 0;
               configure(7'h7F, 8'd255, 16'd3);
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 51;
               configure(7'($urandom_range(0, 127)), 8'($urandom_range(0, 6)),
                         16'($urandom_range(0, 24)));
            end
            default: begin
               send_idle_pct = 24; recv_stall_pct = 24;
               configure(7'($urandom_range(0, 127)), 8'($urandom_range(0, 6)),
                         16'($urandom_range(0, 24)));
            end
         endcase
         run_random(30);
         settle();
      end

      repeat (8) @(posedge clock);
      if (board.fails == 0 && board.outstanding() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
